// ----- design/mtc_pkg.sv -----
`default_nettype none

package mtc_pkg;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  localparam logic [7:0] CHAR_NL     = 8'h0A;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_DASH   = 8'h2D;
  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_SLASH  = 8'h2F;
  localparam logic [7:0] CHAR_0      = 8'h30;
  localparam logic [7:0] CHAR_9      = 8'h39;
  localparam logic [7:0] CHAR_A      = 8'h41;
  localparam logic [7:0] CHAR_Z      = 8'h5A;
  localparam logic [7:0] CHAR_LOW_A  = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  localparam int         CODE_COUNT  = 36;
  localparam int         LETTERS     = 26;
  localparam logic [2:0] MAX_SYMBOLS = 3'd5;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // One unit of back-end work: sym_len symbols, then char_a, then an optional newline.
  typedef struct packed {
    logic [4:0] sym;
    logic [2:0] sym_len;
    logic [7:0] char_a;
    logic       has_nl;
  } job_t;

  // {length, pattern}; symbol k in bit k, 1 = dash
  function automatic logic [7:0] code_entry(input logic [5:0] idx);
    logic [7:0] e;
    unique case (idx)
      6'd0:  e = {3'd2, 5'b00010};
      6'd1:  e = {3'd4, 5'b00001};
      6'd2:  e = {3'd4, 5'b00101};
      6'd3:  e = {3'd3, 5'b00001};
      6'd4:  e = {3'd1, 5'b00000};
      6'd5:  e = {3'd4, 5'b00100};
      6'd6:  e = {3'd3, 5'b00011};
      6'd7:  e = {3'd4, 5'b00000};
      6'd8:  e = {3'd2, 5'b00000};
      6'd9:  e = {3'd4, 5'b01110};
      6'd10: e = {3'd3, 5'b00101};
      6'd11: e = {3'd4, 5'b00010};
      6'd12: e = {3'd2, 5'b00011};
      6'd13: e = {3'd2, 5'b00001};
      6'd14: e = {3'd3, 5'b00111};
      6'd15: e = {3'd4, 5'b00110};
      6'd16: e = {3'd4, 5'b01011};
      6'd17: e = {3'd3, 5'b00010};
      6'd18: e = {3'd3, 5'b00000};
      6'd19: e = {3'd1, 5'b00001};
      6'd20: e = {3'd3, 5'b00100};
      6'd21: e = {3'd4, 5'b01000};
      6'd22: e = {3'd3, 5'b00110};
      6'd23: e = {3'd4, 5'b01001};
      6'd24: e = {3'd4, 5'b01101};
      6'd25: e = {3'd4, 5'b00011};
      6'd26: e = {3'd5, 5'b11111};
      6'd27: e = {3'd5, 5'b11110};
      6'd28: e = {3'd5, 5'b11100};
      6'd29: e = {3'd5, 5'b11000};
      6'd30: e = {3'd5, 5'b10000};
      6'd31: e = {3'd5, 5'b00000};
      6'd32: e = {3'd5, 5'b00001};
      6'd33: e = {3'd5, 5'b00011};
      6'd34: e = {3'd5, 5'b00111};
      6'd35: e = {3'd5, 5'b01111};
      default: e = 8'd0;
    endcase
    return e;
  endfunction

  function automatic logic [7:0] code_char(input logic [5:0] idx);
    logic [7:0] c;
    if (idx < 6'(LETTERS)) begin
      c = CHAR_A + {2'b00, idx};
    end else begin
      c = CHAR_0 + {2'b00, idx - 6'(LETTERS)};
    end
    return c;
  endfunction

  // {found, index} for an uppercase letter or a digit
  function automatic logic [6:0] char_index(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c >= CHAR_A && c <= CHAR_Z) begin
      r = {1'b1, 6'(c - CHAR_A)};
    end else if (c >= CHAR_0 && c <= CHAR_9) begin
      r = {1'b1, 6'(c - CHAR_0 + 8'(LETTERS))};
    end
    return r;
  endfunction

  // Parallel match against all codes; 0 when none matches.
  function automatic logic [7:0] decode_symbols(input logic [4:0] sym, input logic [2:0] len);
    logic [7:0] res;
    logic [7:0] e;
    res = 8'd0;
    for (int i = 0; i < CODE_COUNT; i++) begin
      e = code_entry(6'(i));
      if (e[7:5] == len && e[4:0] == sym) begin
        res = code_char(6'(i));
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- design/mtc_in_if.sv -----
`default_nettype none

interface mtc_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] char_in;

  modport source (output valid, output operation, output char_in, input ready);
  modport sink (input valid, input operation, input char_in, output ready);
endinterface

`default_nettype wire

// ----- design/mtc_out_if.sv -----
`default_nettype none

interface mtc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last_of_run;

  modport source (output valid, output char_out, output last_of_run, input ready);
  modport sink (input valid, input char_out, input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- design/morse_text_codec.sv -----
// Morse text codec, one ASCII byte per input transfer.
// Each job goes into the job queue, then the back end's job register, then the output
// register. One input per cycle is taken while the 2-deep queue has room; the back end
// sends one byte per cycle while dout is ready: 1 to 6 per encode, 0 to 2 per decode.
// Reset (rst, synchronous): clears the decode token, the job queue and the output stage.
`default_nettype none

module morse_text_codec (
  input  wire logic  clk,
  input  wire logic  rst,
  mtc_in_if.sink     din,
  mtc_out_if.source  dout
);

  mtc_pkg::job_t push_job;
  logic          push_valid;
  logic          push_ready;
  mtc_pkg::job_t pop_job;
  logic          pop_valid;
  logic          pop_ready;

  mtc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .din        (din),
    .push_job   (push_job),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  mtc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_job   (push_job),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_job    (pop_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  mtc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_job   (pop_job),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .dout      (dout)
  );

endmodule

`default_nettype wire

// ----- design/mtc_front.sv -----
`default_nettype none

module mtc_front (
  input  wire logic         clk,
  input  wire logic         rst,
  mtc_in_if.sink            din,
  output mtc_pkg::job_t     push_job,
  output logic              push_valid,
  input  wire logic         push_ready
);

  logic [4:0] token_symbols;
  logic [2:0] token_length;
  logic       token_invalid;
  logic       token_is_slash;

  logic [4:0] token_symbols_next;
  logic [2:0] token_length_next;
  logic       token_invalid_next;
  logic       token_is_slash_next;

  logic       accept;
  logic [7:0] upper;
  logic [6:0] enc_idx;
  logic [7:0] enc_entry;
  logic [7:0] decoded;
  logic       is_term;
  logic       has_job;

  assign din.ready = push_ready;
  assign accept    = din.valid && push_ready;
  assign is_term   = din.char_in == mtc_pkg::CHAR_SPACE || din.char_in == mtc_pkg::CHAR_NL;

  always_comb begin
    upper = din.char_in;
    if (din.char_in >= mtc_pkg::CHAR_LOW_A && din.char_in <= mtc_pkg::CHAR_LOW_Z) begin
      upper = din.char_in - mtc_pkg::CASE_OFFSET;
    end
  end

  assign enc_idx   = mtc_pkg::char_index(upper);
  assign enc_entry = mtc_pkg::code_entry(enc_idx[5:0]);

  always_comb begin
    if (token_invalid) begin
      decoded = 8'd0;
    end else if (token_is_slash || token_length == 3'd0) begin
      decoded = mtc_pkg::CHAR_SPACE;
    end else begin
      decoded = mtc_pkg::decode_symbols(token_symbols, token_length);
    end
  end

  // Classify the byte into a job for the back end
  always_comb begin
    push_job = '0;
    has_job  = 1'b1;
    if (din.operation == mtc_pkg::OP_ENCODE) begin
      push_job.char_a = mtc_pkg::CHAR_SPACE;
      if (is_term) begin
        push_job.char_a = din.char_in;
      end else if (enc_idx[6]) begin
        push_job.sym     = enc_entry[4:0];
        push_job.sym_len = enc_entry[7:5];
      end
    end else begin
      push_job.char_a = decoded;
      push_job.has_nl = din.char_in == mtc_pkg::CHAR_NL;
      has_job         = is_term;
    end
  end

  assign push_valid = din.valid && has_job;

  always_comb begin
    token_symbols_next  = token_symbols;
    token_length_next   = token_length;
    token_invalid_next  = token_invalid;
    token_is_slash_next = token_is_slash;
    if (is_term) begin
      token_symbols_next  = 5'd0;
      token_length_next   = 3'd0;
      token_invalid_next  = 1'b0;
      token_is_slash_next = 1'b0;
    end else if (!token_invalid) begin
      if (din.char_in == mtc_pkg::CHAR_DOT || din.char_in == mtc_pkg::CHAR_DASH) begin
        if (token_is_slash || token_length >= mtc_pkg::MAX_SYMBOLS) begin
          token_invalid_next = 1'b1;
        end else begin
          if (din.char_in == mtc_pkg::CHAR_DASH) begin
            token_symbols_next[token_length] = 1'b1;
          end
          token_length_next = token_length + 3'd1;
        end
      end else if (din.char_in == mtc_pkg::CHAR_SLASH && token_length == 3'd0 &&
                   !token_is_slash) begin
        token_is_slash_next = 1'b1;
      end else begin
        token_invalid_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_symbols  <= 5'd0;
      token_length   <= 3'd0;
      token_invalid  <= 1'b0;
      token_is_slash <= 1'b0;
    end else if (accept && din.operation == mtc_pkg::OP_DECODE) begin
      token_symbols  <= token_symbols_next;
      token_length   <= token_length_next;
      token_invalid  <= token_invalid_next;
      token_is_slash <= token_is_slash_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/mtc_queue.sv -----
`default_nettype none

module mtc_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire mtc_pkg::job_t  push_job,
  input  wire logic           push_valid,
  output logic                push_ready,
  output mtc_pkg::job_t       pop_job,
  output logic                pop_valid,
  input  wire logic           pop_ready
);

  mtc_pkg::job_t               entries [mtc_pkg::QUEUE_DEPTH];
  logic [mtc_pkg::QPTR_W-1:0]  wr_ptr;
  logic [mtc_pkg::QPTR_W-1:0]  rd_ptr;
  logic [mtc_pkg::QPTR_W:0]    count;
  logic                        do_push;
  logic                        do_pop;

  assign push_ready = count != (mtc_pkg::QPTR_W + 1)'(mtc_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_job    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == mtc_pkg::QPTR_W'(mtc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == mtc_pkg::QPTR_W'(mtc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/mtc_back.sv -----
`default_nettype none

module mtc_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire mtc_pkg::job_t  pop_job,
  input  wire logic           pop_valid,
  output logic                pop_ready,
  mtc_out_if.source           dout
);

  localparam logic [1:0] PH_SYM = 2'd0;
  localparam logic [1:0] PH_A   = 2'd1;
  localparam logic [1:0] PH_NL  = 2'd2;

  mtc_pkg::job_t cur;
  logic          busy;
  logic [1:0]    phase;
  logic [2:0]    idx;

  logic [1:0]    phase_next;
  logic [2:0]    idx_next;
  logic          job_done;
  logic          advance;
  logic [7:0]    char_next;
  logic          last_next;

  logic          out_valid;
  logic [7:0]    out_char;
  logic          out_last;

  assign advance   = busy && (!out_valid || dout.ready);
  assign pop_ready = !busy || (advance && job_done);

  always_comb begin
    phase_next = phase;
    idx_next   = idx;
    job_done   = 1'b0;
    char_next  = mtc_pkg::CHAR_NL;
    last_next  = 1'b1;
    unique case (phase)
      PH_SYM: begin
        char_next = cur.sym[idx] ? mtc_pkg::CHAR_DASH : mtc_pkg::CHAR_DOT;
        last_next = 1'b0;
        idx_next  = idx + 3'd1;
        if (idx_next == cur.sym_len) begin
          phase_next = PH_A;
        end
      end
      PH_A: begin
        char_next = cur.char_a;
        last_next = !cur.has_nl;
        if (cur.has_nl) begin
          phase_next = PH_NL;
        end else begin
          job_done = 1'b1;
        end
      end
      PH_NL: begin
        job_done = 1'b1;
      end
      default: begin
        job_done = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= PH_A;
      idx   <= 3'd0;
    end else if (pop_ready && pop_valid) begin
      busy  <= 1'b1;
      phase <= (pop_job.sym_len == 3'd0) ? PH_A : PH_SYM;
      idx   <= 3'd0;
    end else if (advance) begin
      busy  <= !job_done;
      phase <= phase_next;
      idx   <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) begin
      cur <= pop_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_char <= char_next;
      out_last <= last_next;
    end
  end

  assign dout.valid       = out_valid;
  assign dout.char_out    = out_char;
  assign dout.last_of_run = out_last;

`ifndef ASSERT_OFF
  a_sym_in_range: assert property (@(posedge clk) disable iff (rst)
    busy && phase == PH_SYM |-> idx < cur.sym_len)
    else $error("symbol index past token length");

  a_nl_only_when_asked: assert property (@(posedge clk) disable iff (rst)
    busy && phase == PH_NL |-> cur.has_nl)
    else $error("newline phase without newline job");

  a_last_frees_back: assert property (@(posedge clk) disable iff (rst)
    advance && last_next |-> pop_ready)
    else $error("final byte of a job did not free the back end");
`endif

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
module testbench;

  localparam int CYCLE_LIMIT      = 300000;
  localparam int RANDOM_PER_PHASE = 125;
  localparam int SETTLE_CYCLES    = 16;
  localparam int PHASES           = 4;

  localparam logic [7:0] CHAR_UNKNOWN = 8'h00;
  localparam logic [7:0] CHAR_T       = 8'h54;
  localparam logic [7:0] CHAR_X_LOW   = 8'h78;
  localparam logic [7:0] CHAR_BRACKET = 8'h5B;
  localparam logic [0:5][7:0] NO_TYPED = '0;

  // percent of cycles the sender idles / the receiver stalls, per phase
  localparam int SEND_IDLE [PHASES]  = '{0, 84, 0, 30};
  localparam int RECV_STALL [PHASES] = '{0, 0, 84, 30};

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_byte_t;

  typedef struct packed {
    logic       op;
    logic [7:0] ch;
  } in_byte_t;

  // n_typed == 0: expectation comes from the predictor
  typedef struct packed {
    logic            op;
    logic [7:0]      ch;
    logic [2:0]      n_typed;
    logic [0:5][7:0] typed;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #6 clk = ~clk;

  mtc_in_if  din ();
  mtc_out_if dout ();

  morse_text_codec i_dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din.sink),
    .dout (dout.source)
  );

  string morse_of [36] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
    "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
    "..-", "...-", ".--", "-..-", "-.--", "--..",
    "-----", ".----", "..---", "...--", "....-",
    ".....", "-....", "--...", "---..", "----."
  };

  stim_row_t directed_rows [25] = '{
    '{mtc_pkg::OP_ENCODE, mtc_pkg::CHAR_A, 3'd3,
      {mtc_pkg::CHAR_DOT, mtc_pkg::CHAR_DASH, mtc_pkg::CHAR_SPACE, 24'd0}},
    '{mtc_pkg::OP_ENCODE, mtc_pkg::CHAR_LOW_Z, 3'd0, NO_TYPED},
    '{mtc_pkg::OP_ENCODE, mtc_pkg::CHAR_0, 3'd6,
      {mtc_pkg::CHAR_DASH, mtc_pkg::CHAR_DASH, mtc_pkg::CHAR_DASH, mtc_pkg::CHAR_DASH,
       mtc_pkg::CHAR_DASH, mtc_pkg::CHAR_SPACE}},
    '{mtc_pkg::OP_ENCODE, mtc_pkg::CHAR_9, 3'd0, NO_TYPED},
    '{mtc_pkg::OP_ENCODE, mtc_pkg::CHAR_SPACE, 3'd1, {mtc_pkg::CHAR_SPACE, 40'd0}},
    '{mtc_pkg::OP_ENCODE, mtc_pkg::CHAR_NL, 3'd1, {mtc_pkg::CHAR_NL, 40'd0}},
    '{mtc_pkg::OP_ENCODE, 8'h00, 3'd1, {mtc_pkg::CHAR_SPACE, 40'd0}},
    '{mtc_pkg::OP_ENCODE, 8'hFF, 3'd1, {mtc_pkg::CHAR_SPACE, 40'd0}},
    '{mtc_pkg::OP_ENCODE, CHAR_BRACKET, 3'd1, {mtc_pkg::CHAR_SPACE, 40'd0}},
    '{mtc_pkg::OP_DECODE, mtc_pkg::CHAR_SPACE, 3'd1, {mtc_pkg::CHAR_SPACE, 40'd0}},
    '{mtc_pkg::OP_DECODE, mtc_pkg::CHAR_SLASH, 3'd0, NO_TYPED},
    '{mtc_pkg::OP_DECODE, mtc_pkg::CHAR_NL, 3'd2,
      {mtc_pkg::CHAR_SPACE, mtc_pkg::CHAR_NL, 32'd0}},
    '{mtc_pkg::OP_DECODE, mtc_pkg::CHAR_DOT, 3'd0, NO_TYPED},
    // encode in the middle of a token must not disturb it
    '{mtc_pkg::OP_ENCODE, CHAR_T, 3'd2, {mtc_pkg::CHAR_DASH, mtc_pkg::CHAR_SPACE, 32'd0}},
    '{mtc_pkg::OP_DECODE, mtc_pkg::CHAR_DASH, 3'd0, NO_TYPED},
    '{mtc_pkg::OP_DECODE, mtc_pkg::CHAR_SPACE, 3'd0, NO_TYPED},
    '{mtc_pkg::OP_DECODE, CHAR_X_LOW, 3'd0, NO_TYPED},
    '{mtc_pkg::OP_DECODE, mtc_pkg::CHAR_SPACE, 3'd1, {CHAR_UNKNOWN, 40'd0}},
    '{mtc_pkg::OP_DECODE, mtc_pkg::CHAR_DASH, 3'd0, NO_TYPED},
    '{mtc_pkg::OP_DECODE, mtc_pkg::CHAR_DASH, 3'd0, NO_TYPED},
    '{mtc_pkg::OP_DECODE, mtc_pkg::CHAR_DASH, 3'd0, NO_TYPED},
    '{mtc_pkg::OP_DECODE, mtc_pkg::CHAR_DASH, 3'd0, NO_TYPED},
    '{mtc_pkg::OP_DECODE, mtc_pkg::CHAR_DASH, 3'd0, NO_TYPED},
    '{mtc_pkg::OP_DECODE, mtc_pkg::CHAR_DASH, 3'd0, NO_TYPED},
    '{mtc_pkg::OP_DECODE, mtc_pkg::CHAR_NL, 3'd2, {CHAR_UNKNOWN, mtc_pkg::CHAR_NL, 32'd0}}
  };

  // predictor copy of the decode token
  logic [4:0] token_dashes;
  logic [2:0] token_count;
  logic       token_broken;
  logic       token_slash;

  out_byte_t morse_bytes_due [$];
  out_byte_t fresh_bytes [$];
  in_byte_t  pending_run [$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int mismatches    = 0;
  int bytes_checked = 0;
  int items_sent    = 0;
  int decode_items  = 0;
  int cycle_count   = 0;

  function automatic int code_slot(input logic [7:0] c);
    if (c >= mtc_pkg::CHAR_A && c <= mtc_pkg::CHAR_Z) return int'(c - mtc_pkg::CHAR_A);
    if (c >= mtc_pkg::CHAR_0 && c <= mtc_pkg::CHAR_9) return 26 + int'(c - mtc_pkg::CHAR_0);
    return -1;
  endfunction

  function automatic logic [7:0] token_to_char();
    string      code;
    logic [4:0] bits;
    if (token_broken) return CHAR_UNKNOWN;
    if (token_slash || token_count == 3'd0) return mtc_pkg::CHAR_SPACE;
    for (int i = 0; i < 36; i++) begin
      code = morse_of[i];
      bits = '0;
      for (int k = 0; k < code.len(); k++) bits[k] = (code[k] == mtc_pkg::CHAR_DASH);
      if (code.len() == int'(token_count) && bits == token_dashes) begin
        return (i < 26) ? 8'(mtc_pkg::CHAR_A + i) : 8'(mtc_pkg::CHAR_0 + i - 26);
      end
    end
    return CHAR_UNKNOWN;
  endfunction

  function automatic void add_to_token(input logic [7:0] c);
    if (token_broken) return;
    if (c == mtc_pkg::CHAR_DOT || c == mtc_pkg::CHAR_DASH) begin
      if (token_slash || token_count >= mtc_pkg::MAX_SYMBOLS) begin
        token_broken = 1'b1;
      end else begin
        if (c == mtc_pkg::CHAR_DASH) token_dashes[token_count] = 1'b1;
        token_count = token_count + 3'd1;
      end
    end else if (c == mtc_pkg::CHAR_SLASH && token_count == 3'd0 && !token_slash) begin
      token_slash = 1'b1;
    end else begin
      token_broken = 1'b1;
    end
  endfunction

  // Fills fresh_bytes with the bytes one input byte produces.
  function automatic void predict_codec_bytes(input logic op, input logic [7:0] c);
    logic [7:0] u;
    logic [7:0] d;
    int         slot;
    string      code;
    fresh_bytes.delete();
    if (op == mtc_pkg::OP_ENCODE) begin
      u = (c >= mtc_pkg::CHAR_LOW_A && c <= mtc_pkg::CHAR_LOW_Z) ?
          c - mtc_pkg::CASE_OFFSET : c;
      if (u == mtc_pkg::CHAR_SPACE || u == mtc_pkg::CHAR_NL) begin
        fresh_bytes.push_back('{u, 1'b1});
      end else begin
        slot = code_slot(u);
        if (slot >= 0) begin
          code = morse_of[slot];
          for (int k = 0; k < code.len(); k++) begin
            fresh_bytes.push_back('{(code[k] == mtc_pkg::CHAR_DASH) ?
                                    mtc_pkg::CHAR_DASH : mtc_pkg::CHAR_DOT, 1'b0});
          end
        end
        fresh_bytes.push_back('{mtc_pkg::CHAR_SPACE, 1'b1});
      end
    end else if (c == mtc_pkg::CHAR_SPACE || c == mtc_pkg::CHAR_NL) begin
      d = token_to_char();
      token_dashes = '0;
      token_count  = '0;
      token_broken = 1'b0;
      token_slash  = 1'b0;
      fresh_bytes.push_back('{d, c == mtc_pkg::CHAR_SPACE});
      if (c == mtc_pkg::CHAR_NL) fresh_bytes.push_back('{mtc_pkg::CHAR_NL, 1'b1});
    end else begin
      add_to_token(c);
    end
  endfunction

  task automatic transfer_item(input logic op, input logic [7:0] ch,
                               input logic [2:0] n_typed, input logic [0:5][7:0] typed);
    while ($urandom_range(99) < send_idle_pct) begin
      din.valid     <= 1'b0;
      din.operation <= 1'($urandom_range(1));
      din.char_in   <= 8'($urandom_range(255));
      @(posedge clk);
    end
    din.valid     <= 1'b1;
    din.operation <= op;
    din.char_in   <= ch;
    do @(posedge clk); while (!din.ready);
    predict_codec_bytes(op, ch);
    if (n_typed == 3'd0) begin
      foreach (fresh_bytes[k]) morse_bytes_due.push_back(fresh_bytes[k]);
    end else begin
      for (int k = 0; k < n_typed; k++) begin
        morse_bytes_due.push_back('{typed[k], k == n_typed - 1});
      end
    end
    items_sent++;
    if (op == mtc_pkg::OP_DECODE) decode_items++;
  endtask

  function automatic void add_item(input logic op, input logic [7:0] ch);
    pending_run.push_back('{op, ch});
  endfunction

  function automatic logic [7:0] token_end();
    return ($urandom_range(3) == 0) ? mtc_pkg::CHAR_NL : mtc_pkg::CHAR_SPACE;
  endfunction

  // Well-formed tokens with random content, some broken ones, encode bytes and noise.
  function automatic void build_run();
    int    kind;
    int    pick;
    int    n;
    string code;
    pending_run.delete();
    kind = $urandom_range(99);
    if (kind < 45) begin
      pick = $urandom_range(19);
      if (pick == 0) begin
        add_item(mtc_pkg::OP_DECODE, mtc_pkg::CHAR_SLASH);
      end else if (pick != 1) begin
        code = morse_of[$urandom_range(35)];
        for (int k = 0; k < code.len(); k++) begin
          add_item(mtc_pkg::OP_DECODE, code[k]);
          if ($urandom_range(19) == 0) begin
            add_item(mtc_pkg::OP_ENCODE, 8'(mtc_pkg::CHAR_A + $urandom_range(25)));
          end
        end
      end
      add_item(mtc_pkg::OP_DECODE, token_end());
    end else if (kind < 60) begin
      n = $urandom_range(7, 1);
      for (int k = 0; k < n; k++) begin
        pick = $urandom_range(9);
        add_item(mtc_pkg::OP_DECODE,
                 (pick < 4) ? mtc_pkg::CHAR_DOT : (pick < 8) ? mtc_pkg::CHAR_DASH :
                 (pick == 8) ? mtc_pkg::CHAR_SLASH : 8'($urandom_range(255)));
      end
      add_item(mtc_pkg::OP_DECODE, token_end());
    end else if (kind < 90) begin
      pick = $urandom_range(9);
      if (pick < 4) begin
        add_item(mtc_pkg::OP_ENCODE, 8'(mtc_pkg::CHAR_A + $urandom_range(25)));
      end else if (pick < 6) begin
        add_item(mtc_pkg::OP_ENCODE, 8'(mtc_pkg::CHAR_LOW_A + $urandom_range(25)));
      end else if (pick < 8) begin
        add_item(mtc_pkg::OP_ENCODE, 8'(mtc_pkg::CHAR_0 + $urandom_range(9)));
      end else if (pick == 8) begin
        add_item(mtc_pkg::OP_ENCODE, token_end());
      end else begin
        add_item(mtc_pkg::OP_ENCODE, 8'($urandom_range(255)));
      end
    end else begin
      add_item(1'($urandom_range(1)), 8'($urandom_range(255)));
    end
  endfunction

  always @(posedge clk) begin
    dout.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    out_byte_t want;
    if (!rst && dout.valid && dout.ready) begin
      if (morse_bytes_due.size() == 0) begin
        $error("char_out: no transfer expected, got %h (last_of_run %b)",
               dout.char_out, dout.last_of_run);
        mismatches++;
      end else begin
        want = morse_bytes_due.pop_front();
        if (dout.char_out !== want.ch) begin
          $error("char_out: expected %h, got %h", want.ch, dout.char_out);
          mismatches++;
        end
        if (dout.last_of_run !== want.last) begin
          $error("last_of_run: expected %b, got %b", want.last, dout.last_of_run);
          mismatches++;
        end
        bytes_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    int phase_end;
    din.valid     = 1'b0;
    din.operation = mtc_pkg::OP_ENCODE;
    din.char_in   = 8'd0;
    dout.ready    = 1'b0;
    token_dashes  = '0;
    token_count   = '0;
    token_broken  = 1'b0;
    token_slash   = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < PHASES; phase++) begin
      send_idle_pct = SEND_IDLE[phase];
      stall_pct     = RECV_STALL[phase];
      if (phase == 0) begin
        foreach (directed_rows[r]) begin
          transfer_item(directed_rows[r].op, directed_rows[r].ch,
                        directed_rows[r].n_typed, directed_rows[r].typed);
        end
      end
      phase_end = items_sent + RANDOM_PER_PHASE;
      while (items_sent < phase_end) begin
        build_run();
        foreach (pending_run[k]) transfer_item(pending_run[k].op, pending_run[k].ch, 3'd0,
                                               NO_TYPED);
      end
      // sender holds off until the output side has drained
      din.valid <= 1'b0;
      do @(posedge clk); while (morse_bytes_due.size() != 0);
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("summary: %0d input transfers (%0d decode, %0d directed), %0d output bytes",
             items_sent, decode_items, $size(directed_rows), bytes_checked);
    $display("summary: phases with no idling, sender idle, receiver stall and both");
    if (mismatches == 0 && morse_bytes_due.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/mtc_pkg.sv
design/mtc_in_if.sv
design/mtc_out_if.sv
design/mtc_front.sv
design/mtc_queue.sv
design/mtc_back.sv
design/morse_text_codec.sv
test/testbench.sv
